// ===== design/mips_execute_stage_unit_defines.svh =====
// assertion macros for the execute stage
// no dependencies
`ifndef MIPS_EXECUTE_STAGE_UNIT_DEFINES_SVH
`define MIPS_EXECUTE_STAGE_UNIT_DEFINES_SVH
`define MES_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define MES_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ===== design/mes_pkg.sv =====
// shared types and codes of the execute stage
// no dependencies
package mes_pkg;
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_ANDI = 6'h0C;
	localparam logic [5:0] OP_ORI = 6'h0D;
	localparam logic [5:0] OP_XORI = 6'h0E;
	localparam logic [5:0] OP_LUI = 6'h0F;
	localparam logic [5:0] OP_LB = 6'h20;
	localparam logic [5:0] OP_LH = 6'h21;
	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] OP_SB = 6'h28;
	localparam logic [5:0] OP_SH = 6'h29;
	localparam logic [5:0] OP_SW = 6'h2B;
	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MTHI = 6'h11;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MTLO = 6'h13;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV = 6'h1A;
	localparam logic [5:0] FN_DIVU = 6'h1B;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR = 6'h25;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2A;
	localparam logic [1:0] MEM_NONE = 2'd0;
	localparam logic [1:0] MEM_LOAD = 2'd1;
	localparam logic [1:0] MEM_STORE = 2'd2;
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_UNSUP = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	typedef enum logic [1:0] {
		KIND_SIMPLE,
		KIND_MUL,
		KIND_DIV
	} op_kind_t;

	typedef struct packed {
		logic     load;
		logic     start_mul;
		logic     start_div;
		logic     mul_step;
		logic     div_step;
		logic     finish;
		logic     out_take;
	} cmd_t;

	typedef struct packed {
		op_kind_t kind;
		logic     mul_ready;
		logic     div_last;
	} sts_t;

	typedef struct packed {
		logic [31:0] alu_result;
		logic [31:0] store_data;
		logic [4:0]  dest_reg;
		logic        write_enable;
		logic [1:0]  mem_kind;
		logic [1:0]  mem_size;
		logic [1:0]  status;
	} result_t;
endpackage

// ===== design/mes_if.sv =====
// valid/ready channel interfaces for the execute stage
// no dependencies
interface mes_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	modport source(output valid, instruction, operand_a, operand_b, input ready);
	modport sink(input valid, instruction, operand_a, operand_b, output ready);
endinterface

interface mes_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] alu_result;
	logic [31:0] store_data;
	logic [4:0]  dest_reg;
	logic        write_enable;
	logic [1:0]  mem_kind;
	logic [1:0]  mem_size;
	logic [1:0]  status;
	modport source(output valid, alu_result, store_data, dest_reg, write_enable,
		mem_kind, mem_size, status, input ready);
	modport sink(input valid, alu_result, store_data, dest_reg, write_enable,
		mem_kind, mem_size, status, output ready);
endinterface

// ===== design/mes_datapath.sv =====
// execute datapath: decode, alu, hi/lo, multiplier in 16-bit pieces, radix-2 divider
// depends on mes_pkg
module mes_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  mes_pkg::cmd_t   cmd,
	output mes_pkg::sts_t   sts,
	input  logic [31:0]     instruction,
	input  logic [31:0]     operand_a,
	input  logic [31:0]     operand_b,
	output mes_pkg::result_t res
);
	logic [31:0] ir_q, a_q, b_q, hi_q, lo_q;
	mes_pkg::result_t simple_c, res_q;
	logic mtlo_c, mthi_c;
	mes_pkg::op_kind_t kind_c;
	logic [5:0] opc, fn;
	logic [31:0] imm_z, ea;

	// multiplier: four 16x16 partial products, magnitudes, sign fixed at the end
	logic [31:0] ma_q, mb_q;
	logic        mneg_q;
	logic [1:0]  mcnt_q;
	logic [63:0] macc_q;
	logic [31:0] pp;
	logic [15:0] pa, pb;
	logic [5:0]  mshift;
	logic [63:0] mprod;

	// divider
	logic [31:0] dq_q, dr_q, dd_q;
	logic [4:0]  dcnt_q;
	logic        dnq_q, dnr_q;
	logic [32:0] dtrial;

	assign opc = ir_q[31:26];
	assign fn = ir_q[5:0];
	assign imm_z = {16'h0, ir_q[15:0]};
	assign ea = a_q + {{16{ir_q[15]}}, ir_q[15:0]};

	always_comb begin
		simple_c = '0;
		mthi_c = 1'b0;
		mtlo_c = 1'b0;
		kind_c = mes_pkg::KIND_SIMPLE;
		if (opc == mes_pkg::OP_RTYPE) begin
			simple_c.dest_reg = ir_q[15:11];
			simple_c.write_enable = 1'b1;
			unique case (fn)
				mes_pkg::FN_ADD, mes_pkg::FN_ADDU: simple_c.alu_result = a_q + b_q;
				mes_pkg::FN_SUB, mes_pkg::FN_SUBU: simple_c.alu_result = a_q - b_q;
				mes_pkg::FN_AND: simple_c.alu_result = a_q & b_q;
				mes_pkg::FN_OR:  simple_c.alu_result = a_q | b_q;
				mes_pkg::FN_XOR: simple_c.alu_result = a_q ^ b_q;
				mes_pkg::FN_NOR: simple_c.alu_result = ~(a_q | b_q);
				mes_pkg::FN_SLT:
					simple_c.alu_result = {31'h0, $signed(a_q) < $signed(b_q)};
				mes_pkg::FN_SLL: simple_c.alu_result = b_q << ir_q[10:6];
				mes_pkg::FN_SRL: simple_c.alu_result = b_q >> ir_q[10:6];
				mes_pkg::FN_SRA:
					simple_c.alu_result = $unsigned($signed(b_q) >>> ir_q[10:6]);
				mes_pkg::FN_SYSCALL: begin
					simple_c.write_enable = 1'b0;
					simple_c.status = mes_pkg::ST_HALT;
				end
				mes_pkg::FN_MFHI: simple_c.alu_result = hi_q;
				mes_pkg::FN_MFLO: simple_c.alu_result = lo_q;
				mes_pkg::FN_MTHI: begin
					simple_c.write_enable = 1'b0;
					mthi_c = 1'b1;
				end
				mes_pkg::FN_MTLO: begin
					simple_c.write_enable = 1'b0;
					mtlo_c = 1'b1;
				end
				mes_pkg::FN_MULT, mes_pkg::FN_MULTU: begin
					simple_c.write_enable = 1'b0;
					kind_c = mes_pkg::KIND_MUL;
				end
				mes_pkg::FN_DIV, mes_pkg::FN_DIVU: begin
					simple_c.write_enable = 1'b0;
					if (b_q == 32'h0) simple_c.status = mes_pkg::ST_DIVZ;
					else kind_c = mes_pkg::KIND_DIV;
				end
				default: begin
					simple_c.dest_reg = '0;
					simple_c.write_enable = 1'b0;
					simple_c.status = mes_pkg::ST_UNSUP;
				end
			endcase
		end else begin
			simple_c.dest_reg = ir_q[20:16];
			simple_c.write_enable = 1'b1;
			unique case (opc)
				mes_pkg::OP_ADDI, mes_pkg::OP_ADDIU: simple_c.alu_result = ea;
				mes_pkg::OP_ANDI: simple_c.alu_result = a_q & imm_z;
				mes_pkg::OP_ORI:  simple_c.alu_result = a_q | imm_z;
				mes_pkg::OP_XORI: simple_c.alu_result = a_q ^ imm_z;
				mes_pkg::OP_LUI:  simple_c.alu_result = {ir_q[15:0], 16'h0};
				mes_pkg::OP_LB, mes_pkg::OP_LH, mes_pkg::OP_LW,
				mes_pkg::OP_SB, mes_pkg::OP_SH, mes_pkg::OP_SW: begin
					simple_c.alu_result = ea;
					simple_c.store_data = b_q;
					simple_c.mem_kind = opc[3] ? mes_pkg::MEM_STORE : mes_pkg::MEM_LOAD;
					simple_c.write_enable = !opc[3];
					simple_c.mem_size = (opc[1:0] == 2'b00) ? mes_pkg::SIZE_BYTE :
						(opc[1:0] == 2'b01) ? mes_pkg::SIZE_HALF : mes_pkg::SIZE_WORD;
				end
				default: begin
					simple_c.dest_reg = '0;
					simple_c.write_enable = 1'b0;
					simple_c.status = mes_pkg::ST_UNSUP;
				end
			endcase
		end
	end

	assign sts.kind = kind_c;
	assign sts.mul_ready = (mcnt_q == 2'd3);
	assign sts.div_last = (dcnt_q == 5'd0);

	// step order: lo*lo, hi*lo, lo*hi, hi*hi
	assign pa = mcnt_q[0] ? ma_q[31:16] : ma_q[15:0];
	assign pb = mcnt_q[1] ? mb_q[31:16] : mb_q[15:0];
	assign pp = {16'h0, pa} * {16'h0, pb};
	assign mshift = {mcnt_q[1] & mcnt_q[0], mcnt_q[1] ^ mcnt_q[0], 4'h0};
	assign mprod = mneg_q ? 64'h0 - macc_q : macc_q;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ir_q <= instruction;
			a_q <= operand_a;
			b_q <= operand_b;
		end
		if (cmd.start_mul) begin
			ma_q <= (fn == mes_pkg::FN_MULT && a_q[31]) ? 32'h0 - a_q : a_q;
			mb_q <= (fn == mes_pkg::FN_MULT && b_q[31]) ? 32'h0 - b_q : b_q;
			mneg_q <= (fn == mes_pkg::FN_MULT) && (a_q[31] ^ b_q[31]);
			macc_q <= '0;
		end
		if (cmd.mul_step) macc_q <= macc_q + ({32'h0, pp} << mshift);
		if (cmd.start_div) begin
			dnr_q <= (fn == mes_pkg::FN_DIV) && a_q[31];
			dnq_q <= (fn == mes_pkg::FN_DIV) && (a_q[31] ^ b_q[31]);
			dq_q <= (fn == mes_pkg::FN_DIV && a_q[31]) ? 32'h0 - a_q : a_q;
			dd_q <= (fn == mes_pkg::FN_DIV && b_q[31]) ? 32'h0 - b_q : b_q;
			dr_q <= '0;
		end
		if (cmd.div_step) begin
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= {dr_q[30:0], dq_q[31]};
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
		if (cmd.finish) res_q <= simple_c;
	end

	// step counters and hi/lo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
			dcnt_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
		end else begin
			if (cmd.start_mul) mcnt_q <= '0;
			else if (cmd.mul_step) mcnt_q <= mcnt_q + 2'd1;
			if (cmd.start_div) dcnt_q <= 5'd31;
			else if (cmd.div_step) dcnt_q <= dcnt_q - 5'd1;
			if (cmd.finish) begin
				if (mthi_c) hi_q <= a_q;
				if (mtlo_c) lo_q <= a_q;
				if (kind_c == mes_pkg::KIND_MUL) begin
					hi_q <= mprod[63:32];
					lo_q <= mprod[31:0];
				end
				if (kind_c == mes_pkg::KIND_DIV) begin
					lo_q <= dnq_q ? 32'h0 - dq_q : dq_q;
					hi_q <= dnr_q ? 32'h0 - dr_q : dr_q;
				end
			end
		end
	end

	assign res = res_q;
endmodule

// ===== design/mes_ctrl.sv =====
// execute controller: load, multiply/divide sequencing, output hold
// depends on mes_pkg
module mes_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mes_pkg::sts_t sts,
	output mes_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;
	state_t state_q;
	logic out_full_q;

	assign in_ready = (state_q == S_IDLE) && (!out_full_q || out_ready);
	assign out_valid = out_full_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.start_mul = (state_q == S_DECODE) && (sts.kind == mes_pkg::KIND_MUL);
		cmd.start_div = (state_q == S_DECODE) && (sts.kind == mes_pkg::KIND_DIV);
		cmd.mul_step = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish = ((state_q == S_DECODE) && (sts.kind == mes_pkg::KIND_SIMPLE))
			|| (state_q == S_DONE);
		cmd.out_take = out_valid && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_full_q <= 1'b0;
		end else begin
			if (cmd.finish) out_full_q <= 1'b1;
			else if (cmd.out_take) out_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_DECODE;
				S_DECODE: begin
					unique case (sts.kind)
						mes_pkg::KIND_MUL: state_q <= S_MUL;
						mes_pkg::KIND_DIV: state_q <= S_DIV;
						default: state_q <= S_IDLE;
					endcase
				end
				S_MUL: if (sts.mul_ready) state_q <= S_DONE;
				S_DIV: if (sts.div_last) state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/mes_core.sv =====
// joins controller and datapath and drives the channels
// depends on mes_pkg, mes_ctrl, mes_datapath
module mes_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      instruction,
	input  logic [31:0]      operand_a,
	input  logic [31:0]      operand_b,
	output logic             out_valid,
	input  logic             out_ready,
	output mes_pkg::result_t res
);
	mes_pkg::cmd_t cmd;
	mes_pkg::sts_t sts;

	mes_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd);
	mes_datapath u_dp (.clk, .arst_n, .cmd, .sts, .instruction, .operand_a,
		.operand_b, .res);
endmodule

// ===== design/mips_execute_stage_unit.sv =====
// Executes one MIPS32 integer instruction per item and gives one result item. For simple
// instructions the result is registered in the cycle after acceptance. MULT/MULTU pass
// through S_DECODE, S_MUL (four 16x16 partial products through one multiplier, one per
// cycle) and S_DONE; DIV/DIVU pass through S_DECODE, S_DIV (one quotient bit per cycle in
// a restoring divider) and S_DONE. One item is in flight at a time: the next item is
// accepted only once the previous one has finished and its result is taken or being taken
// in the same cycle. HI and LO reset to zero.
// depends on mes_pkg, mes_if, mes_core, mips_execute_stage_unit_defines.svh
`include "mips_execute_stage_unit_defines.svh"
module mips_execute_stage_unit (
	input  logic       clk,
	input  logic       arst_n,
	mes_in_if.sink     in_ch,
	mes_out_if.source  out_ch
);
	mes_pkg::result_t res;

	mes_core u_core (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.instruction(in_ch.instruction), .operand_a(in_ch.operand_a),
		.operand_b(in_ch.operand_b), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.res);

	assign out_ch.alu_result = res.alu_result;
	assign out_ch.store_data = res.store_data;
	assign out_ch.dest_reg = res.dest_reg;
	assign out_ch.write_enable = res.write_enable;
	assign out_ch.mem_kind = res.mem_kind;
	assign out_ch.mem_size = res.mem_size;
	assign out_ch.status = res.status;

	`MES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(res))
	`MES_ASSERT_IMPL(a_unsup_clean, clk, arst_n,
		out_ch.valid && res.status == mes_pkg::ST_UNSUP,
		!res.write_enable && res.mem_kind == mes_pkg::MEM_NONE)
	`MES_ASSERT_IMPL(a_store_no_we, clk, arst_n,
		out_ch.valid && res.mem_kind == mes_pkg::MEM_STORE, !res.write_enable)
endmodule

// ===== sim/tb_mips_execute_stage_unit.sv =====
// self-checking testbench for mips_execute_stage_unit: directed rows then random instructions
// checked field by field against a behavioral predictor that keeps its own hi/lo copy
// depends on mes_pkg, mes_if and the design files
module tb_mips_execute_stage_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0]      instr;
		logic [31:0]      a;
		logic [31:0]      b;
		bit               known;
		mes_pkg::result_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	mes_in_if in_ch();
	mes_out_if out_ch();

	mips_execute_stage_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	mes_pkg::result_t expected_q[$];
	logic [31:0]      hi_model;
	logic [31:0]      lo_model;
	int               errors = 0;
	int               cycles = 0;
	int               out_wait = 0;
	bit               stim_done = 1'b0;
	row_t             rows[$];

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rd, logic [4:0] sa);
		return {mes_pkg::OP_RTYPE, 5'd3, 5'd4, rd, sa, fn};
	endfunction

	function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rt, logic [15:0] imm);
		return {op, 5'd5, rt, imm};
	endfunction

	function automatic mes_pkg::result_t execute_instr(logic [31:0] ir, logic [31:0] a,
		logic [31:0] b);
		mes_pkg::result_t r;
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  sa;
		logic [15:0] imm;
		logic [31:0] ea;
		logic [63:0] p;
		logic [31:0] ua;
		logic [31:0] ub;
		op = ir[31:26];
		fn = ir[5:0];
		sa = ir[10:6];
		imm = ir[15:0];
		r = '0;
		ea = a + {{16{imm[15]}}, imm};
		if (op == mes_pkg::OP_RTYPE) begin
			r.dest_reg = ir[15:11];
			r.write_enable = 1'b1;
			case (fn)
				mes_pkg::FN_ADD, mes_pkg::FN_ADDU: r.alu_result = a + b;
				mes_pkg::FN_SUB, mes_pkg::FN_SUBU: r.alu_result = a - b;
				mes_pkg::FN_AND: r.alu_result = a & b;
				mes_pkg::FN_OR: r.alu_result = a | b;
				mes_pkg::FN_XOR: r.alu_result = a ^ b;
				mes_pkg::FN_NOR: r.alu_result = ~(a | b);
				mes_pkg::FN_SLT: r.alu_result = {31'd0, $signed(a) < $signed(b)};
				mes_pkg::FN_SLL: r.alu_result = b << sa;
				mes_pkg::FN_SRL: r.alu_result = b >> sa;
				mes_pkg::FN_SRA: r.alu_result = $signed(b) >>> sa;
				mes_pkg::FN_SYSCALL: begin
					r.write_enable = 1'b0;
					r.status = mes_pkg::ST_HALT;
				end
				mes_pkg::FN_MFHI: r.alu_result = hi_model;
				mes_pkg::FN_MFLO: r.alu_result = lo_model;
				mes_pkg::FN_MTHI: begin
					r.write_enable = 1'b0;
					hi_model = a;
				end
				mes_pkg::FN_MTLO: begin
					r.write_enable = 1'b0;
					lo_model = a;
				end
				mes_pkg::FN_MULT, mes_pkg::FN_MULTU: begin
					if (fn == mes_pkg::FN_MULT)
						p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					else
						p = {32'd0, a} * {32'd0, b};
					{hi_model, lo_model} = p;
					r.write_enable = 1'b0;
				end
				mes_pkg::FN_DIV, mes_pkg::FN_DIVU: begin
					r.write_enable = 1'b0;
					if (b == 0) begin
						r.status = mes_pkg::ST_DIVZ;
					end else if (fn == mes_pkg::FN_DIVU) begin
						lo_model = a / b;
						hi_model = a % b;
					end else begin
						ua = a[31] ? -a : a;
						ub = b[31] ? -b : b;
						lo_model = (a[31] != b[31]) ? -(ua / ub) : ua / ub;
						hi_model = a[31] ? -(ua % ub) : ua % ub;
					end
				end
				default: begin
					r = '0;
					r.status = mes_pkg::ST_UNSUP;
				end
			endcase
		end else begin
			r.dest_reg = ir[20:16];
			r.write_enable = 1'b1;
			case (op)
				mes_pkg::OP_ADDI, mes_pkg::OP_ADDIU: r.alu_result = ea;
				mes_pkg::OP_ANDI: r.alu_result = a & {16'd0, imm};
				mes_pkg::OP_ORI: r.alu_result = a | {16'd0, imm};
				mes_pkg::OP_XORI: r.alu_result = a ^ {16'd0, imm};
				mes_pkg::OP_LUI: r.alu_result = {imm, 16'd0};
				mes_pkg::OP_LB, mes_pkg::OP_LH, mes_pkg::OP_LW,
				mes_pkg::OP_SB, mes_pkg::OP_SH, mes_pkg::OP_SW: begin
					r.alu_result = ea;
					r.store_data = b;
					r.mem_kind = op[3] ? mes_pkg::MEM_STORE : mes_pkg::MEM_LOAD;
					r.mem_size = (op[1:0] == 2'b00) ? mes_pkg::SIZE_BYTE :
						(op[1:0] == 2'b01) ? mes_pkg::SIZE_HALF : mes_pkg::SIZE_WORD;
					if (op[3])
						r.write_enable = 1'b0;
				end
				default: begin
					r = '0;
					r.status = mes_pkg::ST_UNSUP;
				end
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("error at cycle %0d: %s got %h want %h", cycles, field, got, want);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] random_instr();
		logic [5:0] fns[20];
		logic [5:0] ops[12];
		logic [31:0] w;
		fns = '{mes_pkg::FN_ADD, mes_pkg::FN_ADDU, mes_pkg::FN_SUB, mes_pkg::FN_SUBU,
			mes_pkg::FN_AND, mes_pkg::FN_OR, mes_pkg::FN_XOR, mes_pkg::FN_NOR,
			mes_pkg::FN_SLT, mes_pkg::FN_SLL, mes_pkg::FN_SRL, mes_pkg::FN_SRA,
			mes_pkg::FN_SYSCALL, mes_pkg::FN_MFHI, mes_pkg::FN_MTHI, mes_pkg::FN_MFLO,
			mes_pkg::FN_MTLO, mes_pkg::FN_MULT, mes_pkg::FN_MULTU, mes_pkg::FN_DIV};
		ops = '{mes_pkg::OP_ADDI, mes_pkg::OP_ADDIU, mes_pkg::OP_ANDI, mes_pkg::OP_ORI,
			mes_pkg::OP_XORI, mes_pkg::OP_LUI, mes_pkg::OP_LB, mes_pkg::OP_LH,
			mes_pkg::OP_LW, mes_pkg::OP_SB, mes_pkg::OP_SH, mes_pkg::OP_SW};
		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				w[31:26] = mes_pkg::OP_RTYPE;
				w[5:0] = ($urandom_range(0, 20) == 20) ? mes_pkg::FN_DIVU :
					fns[$urandom_range(0, 19)];
			end
			4, 5, 6, 7, 8: w[31:26] = ops[$urandom_range(0, 11)];
			default: ;
		endcase
		return w;
	endfunction

	task automatic send_item(logic [31:0] ir, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.instruction <= ir;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		do @(posedge clk); while (!in_ch.ready);
		expected_q.push_back(execute_instr(ir, a, b));
	endtask

	task automatic add_row(logic [31:0] ir, logic [31:0] a, logic [31:0] b, bit known,
		mes_pkg::result_t res);
		row_t rw;
		rw.instr = ir;
		rw.a = a;
		rw.b = b;
		rw.known = known;
		rw.res = res;
		rows.push_back(rw);
	endtask

	initial begin
		mes_pkg::result_t r;
		mes_pkg::result_t pred;
		logic [31:0]      ir;
		in_ch.valid <= 1'b0;
		in_ch.instruction <= '0;
		in_ch.operand_a <= '0;
		in_ch.operand_b <= '0;
		@(posedge arst_n);
		hi_model = '0;
		lo_model = '0;
		r = '0;
		r.dest_reg = 5'd7;
		r.write_enable = 1'b1;
		add_row(r_word(mes_pkg::FN_MFHI, 5'd7, 5'd0), 32'h1234, 32'h5678, 1'b1, r);
		add_row(r_word(mes_pkg::FN_ADD, 5'd1, 5'd0), 32'hFFFF_FFFF, 32'h1, 1'b0, r);
		add_row(r_word(mes_pkg::FN_SUB, 5'd31, 5'd0), 32'h0, 32'h1, 1'b0, r);
		add_row(r_word(mes_pkg::FN_NOR, 5'd0, 5'd0), 32'h0, 32'h0, 1'b0, r);
		add_row(r_word(mes_pkg::FN_SLT, 5'd2, 5'd0), 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, r);
		add_row(r_word(mes_pkg::FN_SRA, 5'd2, 5'd31), 32'h0, 32'h8000_0000, 1'b0, r);
		add_row(r_word(mes_pkg::FN_SLL, 5'd2, 5'd31), 32'h0, 32'hFFFF_FFFF, 1'b0, r);
		add_row(r_word(mes_pkg::FN_SRL, 5'd2, 5'd31), 32'h0, 32'hFFFF_FFFF, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MULT, 5'd0, 5'd0), 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MFHI, 5'd9, 5'd0), 32'h0, 32'h0, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MULTU, 5'd0, 5'd0), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MFLO, 5'd9, 5'd0), 32'h0, 32'h0, 1'b0, r);
		add_row(r_word(mes_pkg::FN_DIV, 5'd0, 5'd0), 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MFLO, 5'd9, 5'd0), 32'h0, 32'h0, 1'b0, r);
		r = '0;
		r.status = mes_pkg::ST_DIVZ;
		add_row(r_word(mes_pkg::FN_DIVU, 5'd0, 5'd0), 32'h5, 32'h0, 1'b1, r);
		add_row(r_word(mes_pkg::FN_DIV, 5'd0, 5'd0), 32'hFFFF_FFF9, 32'h2, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MTHI, 5'd0, 5'd0), 32'hDEAD_BEEF, 32'h0, 1'b0, r);
		add_row(r_word(mes_pkg::FN_MFHI, 5'd4, 5'd0), 32'h0, 32'h0, 1'b0, r);
		r = '0;
		r.status = mes_pkg::ST_HALT;
		r.dest_reg = 5'd6;
		add_row(r_word(mes_pkg::FN_SYSCALL, 5'd6, 5'd0), 32'h0, 32'h0, 1'b1, r);
		r = '0;
		r.status = mes_pkg::ST_UNSUP;
		add_row({mes_pkg::OP_RTYPE, 20'hFFFFF, 6'h3F}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, r);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, r);
		add_row(i_word(mes_pkg::OP_LUI, 5'd8, 16'hFFFF), 32'h0, 32'h0, 1'b0, r);
		add_row(i_word(mes_pkg::OP_ADDI, 5'd8, 16'h8000), 32'h0, 32'h0, 1'b0, r);
		add_row(i_word(mes_pkg::OP_LB, 5'd31, 16'hFFFF), 32'h0, 32'hAAAA_5555, 1'b0, r);
		add_row(i_word(mes_pkg::OP_SB, 5'd1, 16'h7FFF), 32'hFFFF_FFFF, 32'h5555_AAAA,
			1'b0, r);
		foreach (rows[i]) begin
			send_item(rows[i].instr, rows[i].a, rows[i].b);
			if (rows[i].known) begin
				pred = expected_q[$];
				if (pred != rows[i].res)
					report_mismatch("table row", 32'(i), 32'd0);
			end
		end
		for (int n = 0; n < 1150; n++) begin
			if (n == 500) begin
				in_ch.valid <= 1'b0;
				wait (expected_q.size() == 0);
			end
			if ($urandom_range(0, 3) == 0)
				ir = {mes_pkg::OP_RTYPE, 5'd0, 5'd0, 5'($urandom), 5'd0,
					($urandom_range(0, 1) ? mes_pkg::FN_MFHI : mes_pkg::FN_MFLO)};
			else
				ir = random_instr();
			send_item(ir, pick_operand(), pick_operand());
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		mes_pkg::result_t got;
		mes_pkg::result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.alu_result = out_ch.alu_result;
				got.store_data = out_ch.store_data;
				got.dest_reg = out_ch.dest_reg;
				got.write_enable = out_ch.write_enable;
				got.mem_kind = out_ch.mem_kind;
				got.mem_size = out_ch.mem_size;
				got.status = out_ch.status;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected item", got.alu_result, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (got.alu_result !== want.alu_result)
						report_mismatch("alu_result", got.alu_result, want.alu_result);
					if (got.store_data !== want.store_data)
						report_mismatch("store_data", got.store_data, want.store_data);
					if (got.dest_reg !== want.dest_reg)
						report_mismatch("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
					if (got.write_enable !== want.write_enable)
						report_mismatch("write_enable", 32'(got.write_enable),
							32'(want.write_enable));
					if (got.mem_kind !== want.mem_kind)
						report_mismatch("mem_kind", 32'(got.mem_kind), 32'(want.mem_kind));
					if (got.mem_size !== want.mem_size)
						report_mismatch("mem_size", 32'(got.mem_size), 32'(want.mem_size));
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
				end
				out_wait = $urandom_range(0, 6);
			end else if (out_wait != 0) begin
				out_wait--;
			end
			out_ch.ready <= (out_wait == 0);
		end else begin
			out_ch.ready <= 1'b0;
		end
	end

	initial begin
		@(posedge arst_n);
		wait (stim_done && expected_q.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("mips_execute_stage_unit: match");
		else
			$display("mips_execute_stage_unit: mismatch");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("mips_execute_stage_unit: mismatch");
				$finish;
			end
		end
	end
endmodule

// ===== mips_execute_stage_unit.f =====
+incdir+design
design/mes_pkg.sv
design/mes_if.sv
design/mes_datapath.sv
design/mes_ctrl.sv
design/mes_core.sv
design/mips_execute_stage_unit.sv
sim/tb_mips_execute_stage_unit.sv
